// ===== src/bounded_circular_list_engine_top_macros.svh =====
// assertion macros used by the circular list engine rtl
// no dependencies; included by bcle_dpath, which carries the concurrent checks
`ifndef BOUNDED_CIRCULAR_LIST_ENGINE_TOP_MACROS_SVH
`define BOUNDED_CIRCULAR_LIST_ENGINE_TOP_MACROS_SVH

// condition holds at every clock edge out of reset
`define BCLE_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define BCLE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ===== src/bcle_pkg.sv =====
// types and constants for the circular list engine
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package bcle_pkg;

  localparam int unsigned ListDepth = 16;
  localparam int unsigned ValW      = 32;
  localparam int unsigned PosW      = 8;
  localparam int unsigned StepW     = $clog2(PosW + 1);

  typedef logic [4:0] cnt_t;

  typedef enum logic [1:0] {
    REQ_INS_FRONT = 2'd0,
    REQ_INS_BACK  = 2'd1,
    REQ_DELETE    = 2'd2,
    REQ_READOUT   = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISP,
    S_DEL_DIV,
    S_DEL_RD,
    S_DEL_CAP,
    S_SHIFT,
    S_DEL_END,
    S_RO,
    S_RO_DRAIN
  } state_e;

  typedef struct packed {
    req_e                   req_type;
    logic signed [ValW-1:0] new_value;
    logic [PosW-1:0]        position;
  } in_t;

  typedef struct packed {
    status_e                status;
    logic signed [ValW-1:0] item_value;
    cnt_t                   item_index;
    cnt_t                   entry_count;
    logic                   last_of_run;
  } out_t;

  typedef struct packed {
    logic    load;
    logic    ins_front;
    logic    ins_back;
    logic    res_load;
    status_e res_status;
    logic    res_removed;
    logic    rem_start;
    logic    idx_from_rem;
    logic    idx_clear;
    logic    del_rd;
    logic    cap_removed;
    logic    shift;
    logic    del_finish;
    logic    ro_step;
  } cmd_t;

  typedef struct packed {
    req_e req;
    logic full;
    logic empty;
    logic rem_done;
    logic idx_zero;
    logic shift_more;
    logic ro_last;
  } stat_t;

endpackage

// ===== src/bcle_rem.sv =====
// restoring remainder unit, one dividend bit per cycle
// depends on bcle_pkg; used by bcle_dpath to reduce the delete position
`timescale 1ns / 1ps

module bcle_rem import bcle_pkg::*; #(
  parameter int unsigned CW = 5
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [PosW-1:0] dividend_i,
  input  logic [CW-1:0]   divisor_i,
  output logic            done_o,
  output logic [CW-1:0]   rem_o
);

  logic [StepW-1:0] cnt_q;
  logic             done_q;
  logic [CW-1:0]    r_q;
  logic [PosW-1:0]  sh_q;
  logic [CW-1:0]    div_q;
  logic [CW:0]      trial;
  logic [CW:0]      trial_sub;

  always_comb begin
    trial     = {r_q, sh_q[PosW-1]};
    trial_sub = trial;
    if (trial >= {1'b0, div_q}) begin
      trial_sub = trial - {1'b0, div_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= StepW'(PosW);
      done_q <= 1'b0;
    end else if (cnt_q != '0) begin
      cnt_q  <= cnt_q - StepW'(1);
      done_q <= (cnt_q == StepW'(1));
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      r_q   <= '0;
      sh_q  <= dividend_i;
      div_q <= divisor_i;
    end else if (cnt_q != '0) begin
      r_q  <= trial_sub[CW-1:0];
      sh_q <= {sh_q[PosW-2:0], 1'b0};
    end
  end

  assign done_o = done_q;
  assign rem_o  = r_q;

endmodule

// ===== src/bcle_dpath.sv =====
// datapath: ring store, head and count registers, delete shifter and result register
// depends on bcle_pkg, bcle_rem and the assertion macro header
`timescale 1ns / 1ps
`include "bounded_circular_list_engine_top_macros.svh"

module bcle_dpath import bcle_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  in_t   item_i,
  input  cmd_t  cmd_i,
  output stat_t stat_o,
  output out_t  result_o,
  output logic  result_strobe_o
);

  localparam int unsigned AW = $clog2(ListDepth);
  localparam int unsigned CW = $clog2(ListDepth + 1);
  localparam logic [CW-1:0] DepthC   = CW'(ListDepth);
  localparam logic [AW-1:0] LastSlot = AW'(ListDepth - 1);

  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
                                            input logic [CW-1:0] logical);
    logic [CW:0] s;
    s = {1'b0, logical} + (CW+1)'(base);
    if (s >= (CW+1)'(ListDepth)) begin
      s = s - (CW+1)'(ListDepth);
    end
    return s[AW-1:0];
  endfunction

  logic [ValW-1:0] mem [ListDepth];

  req_e            req_q;
  logic [ValW-1:0] value_q;
  logic [PosW-1:0] pos_q;
  logic [AW-1:0]   head_q, head_d;
  logic [CW-1:0]   count_q, count_d;
  logic [CW-1:0]   idx_q, idx_d;
  logic [ValW-1:0] removed_q;
  logic [ValW-1:0] rdata_q;
  logic            wb_q;
  logic [AW-1:0]   wb_addr_q;
  logic            em_q;
  logic [CW-1:0]   em_idx_q;
  logic            em_last_q;
  out_t            res_q, res_d;
  logic            res_vld_q;

  logic [CW-1:0]   idx_inc;
  logic [AW-1:0]   slot_cur;
  logic [AW-1:0]   slot_nxt;
  logic [AW-1:0]   slot_tail;
  logic [AW-1:0]   head_dec;
  logic [AW-1:0]   head_inc;
  logic            we;
  logic [AW-1:0]   waddr;
  logic [ValW-1:0] wdata;
  logic            rd_en;
  logic [AW-1:0]   raddr;
  logic            rem_done;
  logic [CW-1:0]   rem_val;

  bcle_rem #(
    .CW(CW)
  ) u_rem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.rem_start),
    .dividend_i(pos_q),
    .divisor_i (count_q),
    .done_o    (rem_done),
    .rem_o     (rem_val)
  );

  assign idx_inc   = idx_q + CW'(1);
  assign slot_cur  = slot_of(head_q, idx_q);
  assign slot_nxt  = slot_of(head_q, idx_inc);
  assign slot_tail = slot_of(head_q, count_q);
  assign head_dec  = (head_q == '0) ? LastSlot : head_q - AW'(1);
  assign head_inc  = (head_q == LastSlot) ? '0 : head_q + AW'(1);

  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    idx_d   = idx_q;
    we      = 1'b0;
    waddr   = slot_tail;
    wdata   = value_q;
    rd_en   = 1'b0;
    raddr   = slot_cur;
    if (cmd_i.ins_front) begin
      head_d  = head_dec;
      count_d = count_q + CW'(1);
      we      = 1'b1;
      waddr   = head_dec;
    end
    if (cmd_i.ins_back) begin
      count_d = count_q + CW'(1);
      we      = 1'b1;
      waddr   = slot_tail;
    end
    if (wb_q) begin
      we    = 1'b1;
      waddr = wb_addr_q;
      wdata = rdata_q;
    end
    if (cmd_i.idx_clear) begin
      idx_d = '0;
    end
    if (cmd_i.idx_from_rem) begin
      idx_d = rem_val;
    end
    if (cmd_i.del_rd) begin
      rd_en = 1'b1;
    end
    if (cmd_i.shift) begin
      rd_en = 1'b1;
      raddr = slot_nxt;
      idx_d = idx_inc;
    end
    if (cmd_i.ro_step) begin
      rd_en = 1'b1;
      idx_d = idx_inc;
    end
    if (cmd_i.del_finish) begin
      count_d = count_q - CW'(1);
      if (count_d == '0) begin
        head_d = '0;
      end else if (idx_q == '0) begin
        head_d = head_inc;
      end
    end
  end

  always_comb begin
    res_d = res_q;
    if (cmd_i.res_load) begin
      res_d.status      = cmd_i.res_status;
      res_d.item_value  = cmd_i.res_removed ? removed_q : '0;
      res_d.item_index  = '0;
      res_d.entry_count = cnt_t'(count_d);
      res_d.last_of_run = 1'b1;
    end else if (em_q) begin
      res_d.status      = ST_OK;
      res_d.item_value  = rdata_q;
      res_d.item_index  = cnt_t'(em_idx_q);
      res_d.entry_count = cnt_t'(count_q);
      res_d.last_of_run = em_last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q    <= '0;
      count_q   <= '0;
      idx_q     <= '0;
      wb_q      <= 1'b0;
      em_q      <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      head_q    <= head_d;
      count_q   <= count_d;
      idx_q     <= idx_d;
      wb_q      <= cmd_i.shift;
      em_q      <= cmd_i.ro_step;
      res_vld_q <= cmd_i.res_load | em_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q   <= item_i.req_type;
      value_q <= item_i.new_value;
      pos_q   <= item_i.position;
    end
    if (cmd_i.cap_removed) begin
      removed_q <= rdata_q;
    end
    if (cmd_i.shift) begin
      wb_addr_q <= slot_cur;
    end
    if (cmd_i.ro_step) begin
      em_idx_q  <= idx_inc;
      em_last_q <= (idx_inc == count_q);
    end
    res_q <= res_d;
  end

  // ring store, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata_q <= mem[raddr];
    end
  end

  assign stat_o.req        = req_q;
  assign stat_o.full       = (count_q == DepthC);
  assign stat_o.empty      = (count_q == '0);
  assign stat_o.rem_done   = rem_done;
  assign stat_o.idx_zero   = (idx_q == '0);
  assign stat_o.shift_more = (idx_inc < count_q);
  assign stat_o.ro_last    = (idx_inc == count_q);

  assign result_o        = res_q;
  assign result_strobe_o = res_vld_q;

  `BCLE_ASSERT_ALWAYS(a_count_bound, clk_i, rst_ni, count_q <= DepthC, "count above depth")
  `BCLE_ASSERT_ALWAYS(a_wb_em_excl, clk_i, rst_ni, !(wb_q && em_q), "shift and readout overlap")
  `BCLE_ASSERT_IMPL(a_empty_head, clk_i, rst_ni, count_q == '0, head_q == '0, "head set on empty list")

endmodule

// ===== src/bcle_ctrl.sv =====
// controller state machine: sequences insert, delete and readout beats
// depends on bcle_pkg; drives bcle_dpath through cmd_t and reads stat_t
`timescale 1ns / 1ps

module bcle_ctrl import bcle_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,
  output logic  busy_o,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DISP;
        end
      end
      S_DISP: begin
        state_d = S_IDLE;
        case (stat_i.req)
          REQ_INS_FRONT, REQ_INS_BACK: begin
            cmd_o.res_load = 1'b1;
            if (stat_i.full) begin
              cmd_o.res_status = ST_FULL;
            end else begin
              cmd_o.res_status = ST_OK;
              cmd_o.ins_front  = (stat_i.req == REQ_INS_FRONT);
              cmd_o.ins_back   = (stat_i.req == REQ_INS_BACK);
            end
          end
          REQ_DELETE: begin
            if (stat_i.empty) begin
              cmd_o.res_load   = 1'b1;
              cmd_o.res_status = ST_EMPTY;
            end else begin
              cmd_o.rem_start = 1'b1;
              state_d         = S_DEL_DIV;
            end
          end
          REQ_READOUT: begin
            if (stat_i.empty) begin
              cmd_o.res_load   = 1'b1;
              cmd_o.res_status = ST_EMPTY;
            end else begin
              cmd_o.idx_clear = 1'b1;
              state_d         = S_RO;
            end
          end
          default: begin
            state_d = S_IDLE;
          end
        endcase
      end
      S_DEL_DIV: begin
        if (stat_i.rem_done) begin
          cmd_o.idx_from_rem = 1'b1;
          state_d            = S_DEL_RD;
        end
      end
      S_DEL_RD: begin
        cmd_o.del_rd = 1'b1;
        state_d      = S_DEL_CAP;
      end
      S_DEL_CAP: begin
        cmd_o.cap_removed = 1'b1;
        state_d           = stat_i.idx_zero ? S_DEL_END : S_SHIFT;
      end
      S_SHIFT: begin
        if (stat_i.shift_more) begin
          cmd_o.shift = 1'b1;
        end else begin
          state_d = S_DEL_END;
        end
      end
      S_DEL_END: begin
        cmd_o.del_finish  = 1'b1;
        cmd_o.res_load    = 1'b1;
        cmd_o.res_status  = ST_OK;
        cmd_o.res_removed = 1'b1;
        state_d           = S_IDLE;
      end
      S_RO: begin
        cmd_o.ro_step = 1'b1;
        if (stat_i.ro_last) begin
          state_d = S_RO_DRAIN;
        end
      end
      S_RO_DRAIN: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

// ===== src/bounded_circular_list_engine_top.sv =====
// Ordered circular list of up to 16 signed 32-bit values kept in a ring store with
// one read and one write port. A request is taken when start is high and busy is low;
// every result beat is shown on result_o for exactly one cycle with result_strobe_o
// high and cannot be held off, so the receiver must take each beat as it comes. An
// insert, or a delete or readout on an empty list, gives one beat, loaded into the result
// register from the dispatch state. A delete runs the position through an eight-step
// remainder unit to get p, the position mod count, then moves each entry behind the
// removed one a place forward, one per cycle through the store; when p is zero no entry
// moves and the head advances. A readout streams one beat per cycle from the first entry
// to the last. busy falls in the cycle the final beat is shown.
// depends on bcle_pkg, bcle_ctrl and bcle_dpath
`timescale 1ns / 1ps

module bounded_circular_list_engine_top import bcle_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  in_t  item_i,
  output out_t result_o,
  output logic result_strobe_o
);

  cmd_t  cmd;
  stat_t stat;

  bcle_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .busy_o (busy),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  bcle_dpath u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_i         (item_i),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .result_o       (result_o),
    .result_strobe_o(result_strobe_o)
  );

endmodule
